// File: rtl/core/spq_pkg.sv
// Package with the shared types and constants of the sorted priority queue.
`timescale 1ns / 1ps
package spq_pkg;

  localparam int CAPACITY  = 16;
  localparam int NUM_USERS = 8;
  localparam int POS_W     = 4;
  localparam int CNT_W     = 5;

  localparam logic [2:0] ACT_PUSH    = 3'd0;
  localparam logic [2:0] ACT_POP     = 3'd1;
  localparam logic [2:0] ACT_FIND    = 3'd2;
  localparam logic [2:0] ACT_REMOVE  = 3'd3;
  localparam logic [2:0] ACT_PEEK_LO = 3'd4;
  localparam logic [2:0] ACT_PEEK_HI = 3'd5;

  localparam logic [2:0] STAT_OK     = 3'd0;
  localparam logic [2:0] STAT_FULL   = 3'd1;
  localparam logic [2:0] STAT_EMPTY  = 3'd2;
  localparam logic [2:0] STAT_NOFREE = 3'd3;
  localparam logic [2:0] STAT_BADPOS = 3'd4;

  typedef struct packed {
    logic [2:0]  action;
    logic [15:0] item_value;
    logic [7:0]  item_priority;
    logic [2:0]  item_user;
    logic [7:0]  busy_users;
    logic [3:0]  target_position;
  } req_t;

  typedef struct packed {
    logic [15:0] out_value;
    logic [7:0]  out_priority;
    logic [2:0]  out_user;
    logic [3:0]  out_position;
    logic [2:0]  status;
    logic [4:0]  entry_count;
  } rsp_t;

  typedef struct packed {
    logic [15:0] value;
    logic [7:0]  prio;
    logic [2:0]  user;
  } entry_t;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_EXEC
  } ctrl_state_t;

  typedef struct packed {
    logic load;
    logic exec;
  } spq_cmd_t;

  typedef struct packed {
    logic out_blocked;
  } spq_stat_t;

endpackage

// File: rtl/core/spq_ctrl.sv
// Controller state machine that sequences one queue action at a time.
`timescale 1ns / 1ps
module spq_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_stall,
  input  spq_pkg::spq_stat_t   stat,
  output spq_pkg::spq_cmd_t    cmd
);
  import spq_pkg::*;

  ctrl_state_t state;
  ctrl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_stall  = 1'b1;
    case (state)
      ST_IDLE: begin
        req_stall = 1'b0;
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        // Hold the action until the result register can take a new beat.
        if (!stat.out_blocked) begin
          cmd.exec   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/core/spq_datapath.sv
// Datapath: sorted entry table, fill count, search logic and result register.
`timescale 1ns / 1ps
module spq_datapath (
  input  logic                 clk,
  input  logic                 rst,
  input  spq_pkg::req_t        req,
  input  spq_pkg::spq_cmd_t    cmd,
  output spq_pkg::spq_stat_t   stat,
  output logic                 rsp_valid,
  input  logic                 rsp_stall,
  output spq_pkg::rsp_t        rsp
);
  import spq_pkg::*;

  entry_t             store [CAPACITY];
  entry_t             store_next [CAPACITY];
  logic [CNT_W-1:0]   fill_count;
  logic [CNT_W-1:0]   fill_next;
  logic [CNT_W-1:0]   fill_dec;
  req_t               cur;
  rsp_t               rsp_next;

  logic [CAPACITY-1:0] below;
  logic [CAPACITY-1:0] free;
  logic [POS_W-1:0]    last_pos;
  logic [POS_W-1:0]    free_pos;
  logic [POS_W-1:0]    rd_pos;
  logic [POS_W-1:0]    shift_pos;
  logic                free_hit;
  logic                rd_ok;
  logic                do_insert;
  logic                do_remove;
  logic [2:0]          status_next;
  entry_t              rd_entry;
  entry_t              new_entry;

  assign fill_dec  = fill_count - CNT_W'(1);
  assign last_pos  = fill_dec[POS_W-1:0];
  assign new_entry = '{value: cur.item_value, prio: cur.item_priority,
                       user: cur.item_user};

  // Compare every occupied entry against the request in parallel.
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      below[i] = (CNT_W'(i) < fill_count) && (store[i].prio < cur.item_priority);
      free[i]  = (CNT_W'(i) < fill_count) && (int'(store[i].user) < NUM_USERS)
                 && !cur.busy_users[store[i].user];
    end
  end

  // Highest free position wins.
  always_comb begin
    free_pos = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (free[i]) begin
        free_pos = POS_W'(i);
      end
    end
  end

  assign free_hit = |free;

  always_comb begin
    fill_next   = fill_count;
    status_next = STAT_OK;
    rd_pos      = '0;
    rd_ok       = 1'b0;
    do_insert   = 1'b0;
    do_remove   = 1'b0;
    shift_pos   = '0;
    case (cur.action)
      ACT_PUSH: begin
        if (fill_count == CNT_W'(CAPACITY)) begin
          status_next = STAT_FULL;
        end else begin
          do_insert = 1'b1;
          fill_next = fill_count + CNT_W'(1);
        end
      end
      ACT_POP: begin
        if (fill_count == '0) begin
          status_next = STAT_EMPTY;
        end else begin
          rd_pos    = last_pos;
          rd_ok     = 1'b1;
          do_remove = 1'b1;
          shift_pos = last_pos;
          fill_next = fill_dec;
        end
      end
      ACT_FIND: begin
        if (free_hit) begin
          rd_pos = free_pos;
          rd_ok  = 1'b1;
        end else begin
          status_next = STAT_NOFREE;
        end
      end
      ACT_REMOVE: begin
        if (CNT_W'(cur.target_position) >= fill_count) begin
          status_next = STAT_BADPOS;
        end else begin
          rd_pos    = cur.target_position;
          rd_ok     = 1'b1;
          do_remove = 1'b1;
          shift_pos = cur.target_position;
          fill_next = fill_dec;
        end
      end
      ACT_PEEK_LO: begin
        if (fill_count == '0) begin
          status_next = STAT_EMPTY;
        end else begin
          rd_pos = '0;
          rd_ok  = 1'b1;
        end
      end
      ACT_PEEK_HI: begin
        if (fill_count == '0) begin
          status_next = STAT_EMPTY;
        end else begin
          rd_pos = last_pos;
          rd_ok  = 1'b1;
        end
      end
      default: begin
        status_next = STAT_OK;
      end
    endcase
  end

  assign rd_entry = store[rd_pos];

  // Insert shifts the upper part up by one; removal shifts it down by one.
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      store_next[i] = store[i];
    end
    if (do_insert) begin
      if (!below[0]) begin
        store_next[0] = new_entry;
      end
      for (int i = 1; i < CAPACITY; i++) begin
        if (!below[i]) begin
          store_next[i] = below[i-1] ? new_entry : store[i-1];
        end
      end
    end else if (do_remove) begin
      for (int i = 0; i < CAPACITY - 1; i++) begin
        if (POS_W'(i) >= shift_pos) begin
          store_next[i] = store[i+1];
        end
      end
    end
  end

  always_comb begin
    rsp_next.out_value    = rd_ok ? rd_entry.value    : '0;
    rsp_next.out_priority = rd_ok ? rd_entry.prio     : '0;
    rsp_next.out_user     = rd_ok ? rd_entry.user     : '0;
    rsp_next.out_position = rd_ok ? rd_pos            : '0;
    rsp_next.status       = status_next;
    rsp_next.entry_count  = fill_next;
  end

  assign stat.out_blocked = rsp_valid && rsp_stall;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur <= req;
    end
    if (cmd.exec) begin
      rsp <= rsp_next;
      for (int i = 0; i < CAPACITY; i++) begin
        store[i] <= store_next[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      if (cmd.exec) begin
        fill_count <= fill_next;
        rsp_valid  <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

// File: rtl/core/sorted_priority_queue_free_user.sv
// Top level of the sorted priority queue with free-user search.
// A request beat is latched in the controller's idle state and executed in its
// execute state, which updates the table and loads the result register that
// presents its result beat, unless an earlier result beat is still stalled,
// which holds the execute step. A new request beat is taken only after the load
// and execute steps of the controller around the single parallel-compare table update.
// Reset clears the fill count, the controller and the result valid; the entry
// table needs no reset since only occupied positions are ever read.
`timescale 1ns / 1ps
module sorted_priority_queue_free_user (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  spq_pkg::req_t  req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output spq_pkg::rsp_t  rsp
);
  import spq_pkg::*;

  // Commands from the controller and back-pressure status from the datapath.
  spq_cmd_t  cmd;
  spq_stat_t stat;

  // The controller takes a request beat in its idle state and latches it;
  // in the execute state it updates the table and loads the result register,
  // waiting only while an earlier result beat is still stalled.
  spq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // The datapath holds the table sorted by ascending priority, so a push
  // lands ahead of the first equal or higher priority and equal priorities
  // leave in arrival order. All compares across the table run in parallel.
  spq_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .stat      (stat),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule

// File: tb/sv/sorted_priority_queue_free_user_tb.sv
// Self-checking testbench for the sorted priority queue with free-user search.
`timescale 1ns / 1ps
module sorted_priority_queue_free_user_tb;
  import spq_pkg::*;

  // The two action codes the block leaves unused; they must change nothing.
  localparam logic [2:0] ACT_SPARE_A = 3'd6;
  localparam logic [2:0] ACT_SPARE_B = 3'd7;

  localparam int RANDOM_ITEMS = 700;
  // The slowest legal item adds the longest idle gap from the sender, its pass
  // through the block and the longest stall at the receiver; over about 730 items
  // that stays well inside this limit.
  localparam int CYCLE_LIMIT = 400000;
  // The block registers its answer in the execute step after acceptance; this many
  // quiet cycles at the end leave room for any stray result to show up.
  localparam int TAIL_CYCLES = 8;

  // Own view of one table entry, kept apart from the package entry type.
  typedef struct packed {
    logic [15:0] val;
    logic [7:0]  prio;
    logic [2:0]  owner;
  } slot_t;

  // Shadow of the queue table: it applies every accepted request beat to its own
  // copy of the table and holds the result beats that the block still owes.
  class queue_shadow;
    slot_t       slots[CAPACITY];
    int unsigned fill;
    rsp_t        owed_results[$];
    int unsigned errors;
    int unsigned n_items;
    int unsigned n_checked;
    int unsigned n_full;
    int unsigned n_empty;
    int unsigned n_nofree;
    int unsigned n_badpos;
    int unsigned n_ok_hits;
    int unsigned peak_fill;

    function new();
      fill = 0;
      errors = 0;
      n_items = 0;
      n_checked = 0;
      n_full = 0;
      n_empty = 0;
      n_nofree = 0;
      n_badpos = 0;
      n_ok_hits = 0;
      peak_fill = 0;
    endfunction

    function rsp_t entry_result(slot_t s, int unsigned pos);
      rsp_t res;
      res = '0;
      res.out_value    = s.val;
      res.out_priority = s.prio;
      res.out_user     = s.owner;
      res.out_position = POS_W'(pos);
      res.status       = STAT_OK;
      n_ok_hits++;
      return res;
    endfunction

    // Updates the shadow table for one accepted request beat and queues the
    // result beat it must produce.
    function void apply_action(req_t r);
      rsp_t        res;
      slot_t       s;
      int unsigned pos;
      bit          hit;
      res = '0;
      hit = 1'b0;
      n_items++;
      case (r.action)
        ACT_PUSH: begin
          if (fill >= CAPACITY) begin
            res.status = STAT_FULL;
          end else begin
            // Stop at the first entry with equal or higher priority, so that
            // equal priorities keep their arrival order.
            pos = 0;
            while (pos < fill && r.item_priority > slots[pos].prio) pos++;
            for (int i = fill; i > pos; i--) slots[i] = slots[i - 1];
            slots[pos] = '{val: r.item_value, prio: r.item_priority, owner: r.item_user};
            fill++;
            res.status = STAT_OK;
          end
        end
        ACT_POP: begin
          if (fill == 0) begin
            res.status = STAT_EMPTY;
          end else begin
            res = entry_result(slots[fill - 1], fill - 1);
            fill--;
          end
        end
        ACT_FIND: begin
          for (int i = int'(fill) - 1; i >= 0 && !hit; i--) begin
            s = slots[i];
            if (!(s.owner >= NUM_USERS || r.busy_users[s.owner])) begin
              res = entry_result(s, i);
              hit = 1'b1;
            end
          end
          if (!hit) res.status = STAT_NOFREE;
        end
        ACT_REMOVE: begin
          if (r.target_position >= fill) begin
            res.status = STAT_BADPOS;
          end else begin
            res = entry_result(slots[r.target_position], r.target_position);
            for (int i = r.target_position; i + 1 < fill; i++) slots[i] = slots[i + 1];
            fill--;
          end
        end
        ACT_PEEK_LO, ACT_PEEK_HI: begin
          if (fill == 0) begin
            res.status = STAT_EMPTY;
          end else begin
            pos = (r.action == ACT_PEEK_LO) ? 0 : fill - 1;
            res = entry_result(slots[pos], pos);
          end
        end
        default: res.status = STAT_OK;
      endcase
      res.entry_count = CNT_W'(fill);
      case (res.status)
        STAT_FULL:   n_full++;
        STAT_EMPTY:  n_empty++;
        STAT_NOFREE: n_nofree++;
        STAT_BADPOS: n_badpos++;
        default: ;
      endcase
      if (fill > peak_fill) peak_fill = fill;
      owed_results.push_back(res);
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      end
    endfunction

    // Checks one accepted result beat against the oldest owed result.
    function void check_result(rsp_t got);
      rsp_t want;
      if (owed_results.size() == 0) begin
        errors++;
        $display("%0t: result beat with no request outstanding, actual 0x%0h", $time, got);
        return;
      end
      want = owed_results.pop_front();
      n_checked++;
      compare_field("out_value",    want.out_value,    got.out_value);
      compare_field("out_priority", want.out_priority, got.out_priority);
      compare_field("out_user",     want.out_user,     got.out_user);
      compare_field("out_position", want.out_position, got.out_position);
      compare_field("status",       want.status,       got.status);
      compare_field("entry_count",  want.entry_count,  got.entry_count);
    endfunction
  endclass

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  req_valid = 1'b0;
  logic  req_stall;
  req_t  req = '0;
  logic  rsp_valid;
  logic  rsp_stall = 1'b0;
  rsp_t  rsp;

  queue_shadow shadow;
  int unsigned cycle_count = 0;
  int unsigned burst_left = 0;   // request beats still to send back to back
  bit          draining = 1'b0;  // receiver stops stalling at the end of the run

  sorted_priority_queue_free_user i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always #1 clk = ~clk;

  // Watchdog: a hung handshake or a missing result ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("sorted_priority_queue_free_user test failed");
      $finish;
    end
  end

  // Result side. The stall value read here is the one the block saw at this
  // edge, since the new value is only applied in the nonblocking region.
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) shadow.check_result(rsp);
  end

  // Receiver stalls: mostly short, now and then long, with stretches where the
  // receiver takes every beat. Only one assignment to the stall per edge.
  int unsigned stall_left = 0;
  int unsigned quiet_left = 0;
  always @(posedge clk) begin
    int unsigned pick;
    if (draining) begin
      rsp_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      rsp_stall <= 1'b1;
    end else begin
      rsp_stall <= 1'b0;
      if (quiet_left > 0) begin
        quiet_left--;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 60)      stall_left = 0;
        else if (pick < 90) stall_left = $urandom_range(1, 3);
        else if (pick < 96) stall_left = $urandom_range(4, 12);
        else if (pick < 98) stall_left = $urandom_range(20, 60);
        else                quiet_left = $urandom_range(30, 120);
      end
    end
  end

  // Idle cycles ahead of the next request beat: mostly none or a few, rarely
  // many, and none at all while a back-to-back burst is running.
  function automatic int unsigned pick_gap();
    int unsigned pick;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    pick = $urandom_range(0, 99);
    if (pick < 50) return 0;
    if (pick < 85) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Sends one request beat and holds it until the block takes it, then lets the
  // shadow table account for it. Called at a rising edge.
  task automatic send_request(input req_t r);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= r;
    do @(posedge clk); while (req_stall);
    shadow.apply_action(r);
  endtask

  function automatic req_t make_req(logic [2:0] act, logic [15:0] value, logic [7:0] prio,
                                    logic [2:0] user, logic [7:0] busy, logic [3:0] target);
    req_t r;
    r.action          = act;
    r.item_value      = value;
    r.item_priority   = prio;
    r.item_user       = user;
    r.busy_users      = busy;
    r.target_position = target;
    return r;
  endfunction

  // Random request beat. Fields are random even when the action ignores them;
  // priorities cluster on a few values so that ties are common, and the busy
  // mask often leaves exactly one user free so that the search has to walk.
  function automatic req_t random_request(int unsigned push_pct);
    req_t        r;
    int unsigned pick;
    int unsigned fill;
    fill = shadow.fill;
    r = make_req(3'(ACT_PUSH), 16'($urandom), 8'($urandom), 3'($urandom),
                 8'($urandom), 4'($urandom));
    pick = $urandom_range(0, 99);
    if (pick < 35)      r.item_priority = 8'($urandom_range(0, 3));
    else if (pick < 50) r.item_priority = $urandom_range(0, 1) ? 8'hFF : 8'h00;
    pick = $urandom_range(0, 99);
    if (pick < 5)       r.item_value = 16'h0000;
    else if (pick < 10) r.item_value = 16'hFFFF;
    pick = $urandom_range(0, 99);
    if (pick < 15)      r.busy_users = 8'h00;
    else if (pick < 30) r.busy_users = 8'hFF;
    else if (pick < 60) r.busy_users = ~(8'h01 << $urandom_range(0, 7));
    if ($urandom_range(0, 99) >= push_pct) begin
      pick = $urandom_range(0, 99);
      if (pick < 28)      r.action = ACT_POP;
      else if (pick < 53) r.action = ACT_FIND;
      else if (pick < 75) r.action = ACT_REMOVE;
      else if (pick < 87) r.action = ACT_PEEK_LO;
      else if (pick < 98) r.action = ACT_PEEK_HI;
      else                r.action = $urandom_range(0, 1) ? ACT_SPARE_A : ACT_SPARE_B;
    end
    // Most removals name an occupied position; the rest may point past the top.
    if (r.action == ACT_REMOVE && fill > 0 && $urandom_range(0, 99) < 80)
      r.target_position = 4'($urandom_range(0, fill - 1));
    return r;
  endfunction

  // Priorities of the directed fill: both extremes, and runs of equal values so
  // that the arrival order of ties shows in later pops.
  logic [7:0] fill_prios [16] = '{8'hFF, 8'h00, 8'h80, 8'h80, 8'h80, 8'h00, 8'hFF, 8'h7F,
                                  8'h01, 8'hFE, 8'h80, 8'h40, 8'h00, 8'hC0, 8'hFF, 8'h10};

  initial begin
    int unsigned mode_left;
    int unsigned push_pct;
    int unsigned pick;
    shadow = new();
    mode_left = 0;
    push_pct = 50;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed part. Every read action on an empty table, then an unused code.
    send_request(make_req(ACT_POP,     16'h0, 8'h0, 3'd0, 8'h00, 4'd0));
    send_request(make_req(ACT_PEEK_LO, 16'h0, 8'h0, 3'd0, 8'h00, 4'd0));
    send_request(make_req(ACT_PEEK_HI, 16'h0, 8'h0, 3'd0, 8'h00, 4'd0));
    send_request(make_req(ACT_FIND,    16'h0, 8'h0, 3'd0, 8'h00, 4'd0));
    send_request(make_req(ACT_REMOVE,  16'h0, 8'h0, 3'd0, 8'h00, 4'd0));
    send_request(make_req(ACT_SPARE_A, 16'hFFFF, 8'hFF, 3'd7, 8'hFF, 4'd15));
    // Fill the table to capacity with extreme values and every user.
    for (int i = 0; i < CAPACITY; i++) begin
      send_request(make_req(ACT_PUSH, (i == 0) ? 16'hFFFF : (i == 1) ? 16'h0000 : 16'($urandom),
                            fill_prios[i], 3'(i), 8'h00, 4'd0));
    end
    // A push into the full table, a search with every user busy, removal of
    // the top entry, and a removal just past the new top.
    send_request(make_req(ACT_PUSH,    16'hA5A5, 8'h80, 3'd5, 8'h00, 4'd0));
    send_request(make_req(ACT_FIND,    16'h0, 8'h0, 3'd0, 8'hFF, 4'd0));
    send_request(make_req(ACT_REMOVE,  16'h0, 8'h0, 3'd0, 8'h00, 4'd15));
    send_request(make_req(ACT_REMOVE,  16'h0, 8'h0, 3'd0, 8'h00, 4'd15));
    send_request(make_req(ACT_SPARE_B, 16'h0, 8'h0, 3'd0, 8'h00, 4'd0));

    // Random part in phases that lean toward filling, draining or neither, so
    // the table swings between empty and full many times.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (mode_left == 0) begin
        mode_left = $urandom_range(20, 60);
        pick = $urandom_range(0, 2);
        push_pct = (pick == 0) ? 65 : (pick == 1) ? 20 : 42;
        if ($urandom_range(0, 3) == 0) burst_left = $urandom_range(10, 40);
      end
      mode_left--;
      send_request(random_request(push_pct));
    end
    req_valid <= 1'b0;

    // Wait for every owed result, then give stray results time to appear.
    while (shadow.owed_results.size() != 0) @(posedge clk);
    draining = 1'b1;
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Ran %0d actions and checked %0d results; %0d returned an entry, peak fill %0d.",
             shadow.n_items, shadow.n_checked, shadow.n_ok_hits, shadow.peak_fill);
    $display("Refusals seen: %0d full, %0d empty, %0d no free user, %0d bad position.",
             shadow.n_full, shadow.n_empty, shadow.n_nofree, shadow.n_badpos);
    if (shadow.errors == 0) begin
      $display("sorted_priority_queue_free_user test passed");
    end else begin
      $display("sorted_priority_queue_free_user test failed");
    end
    $finish;
  end

endmodule
